// ----- rtl/swtk_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swtk_pkg
// Shared types and constants of the skinning weight top-k normaliser.
// ----------------------------------------------------------------------------
package swtk_pkg;

   localparam int unsigned WEIGHT_W = 17;
   localparam int unsigned BONE_W   = 8;
   localparam int unsigned SLOTS    = 4;
   localparam int unsigned SUM_W    = 19;
   localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_FETCH,
      ST_MODIFY,
      ST_DIVIDE,
      ST_RESPOND
   } state_type;

endpackage : swtk_pkg
`default_nettype wire

// ----- rtl/swtk_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swtk_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module swtk_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule : swtk_ram
`default_nettype wire

// ----- rtl/swtk_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swtk_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swtk_divider #(
   parameter int unsigned NUM_W = 36,
   parameter int unsigned DEN_W = 19
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numerator,
   input  wire logic [DEN_W-1:0] denominator,
   output      logic             done,
   output      logic [NUM_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         quo_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next numerator bit, subtract where it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : swtk_divider
`default_nettype wire

// ----- rtl/skin_weight_top_k_normalizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// skin_weight_top_k_normalizer
// Keeps the strongest bone influences per control point and reads them back
// normalised to a sum of one.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (op, control_point, bone, weight) under
//   req_valid/req_ready. Add inserts an influence in weight order, clear
//   zeroes an entry, read returns one item on rsp_* under rsp_valid/rsp_ready.
//   All slots of a control point sit in one memory word (weights and bones in
//   two RAMs), so each item costs one read and at most one write.
//   Add and clear pass through fetch, read data and write back. A read
//   fetches alike and then divides all INFLUENCES slots in turn, one
//   quotient bit a cycle in the shared divider; an empty entry skips the
//   divider.
//   One item is in work at a time; req_ready is high only when idle.
//   After reset a clearing pass writes zero to every entry, one a cycle,
//   with req_ready low.
//   A stalled receiver holds the result in the rsp_* registers; no new item
//   is taken until it is delivered.
// ----------------------------------------------------------------------------
module skin_weight_top_k_normalizer #(
   parameter int unsigned INFLUENCES     = 4,
   parameter int unsigned CONTROL_POINTS = 1024,
   parameter int unsigned BONES          = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [9:0]  req_control_point,
   input  wire logic [7:0]  req_bone,
   input  wire logic [16:0] req_weight,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [16:0] rsp_weight_0,
   output      logic [16:0] rsp_weight_1,
   output      logic [16:0] rsp_weight_2,
   output      logic [16:0] rsp_weight_3,
   output      logic [7:0]  rsp_bone_0,
   output      logic [7:0]  rsp_bone_1,
   output      logic [7:0]  rsp_bone_2,
   output      logic [7:0]  rsp_bone_3,
   output      logic        rsp_has_influence
);

   localparam int unsigned WW    = swtk_pkg::WEIGHT_W;
   localparam int unsigned BW    = swtk_pkg::BONE_W;
   localparam int unsigned NS    = swtk_pkg::SLOTS;
   localparam int unsigned SW    = swtk_pkg::SUM_W;
   localparam int unsigned ADDR_W = (CONTROL_POINTS > 1) ? $clog2(CONTROL_POINTS) : 1;
   localparam int unsigned SLOT_W = 2;
   localparam int unsigned NUM_W  = WW + 16 + 3;

   // ---- state ---------------------------------------------------------------
   swtk_pkg::state_type state_ff, state_in;
   swtk_pkg::op_type    op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                cp_ok_ff, cp_ok_in;
   logic [BW-1:0]       bone_ff, bone_in;
   logic [WW-1:0]       wgt_ff, wgt_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [ADDR_W-1:0]   init_ff, init_in;
   logic [NS*WW-1:0]    ent_w_ff, ent_w_in;
   logic [NS*BW-1:0]    ent_b_ff, ent_b_in;
   logic [SW-1:0]       sum_ff, sum_in;
   logic [NS*WW-1:0]    res_w_ff, res_w_in;
   logic                has_ff, has_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // ---- memories ------------------------------------------------------------
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_addr;
   logic [NS*WW-1:0]     mem_wd_w, mem_rd_w;
   logic [NS*BW-1:0]     mem_wd_b, mem_rd_b;

   swtk_ram #(.WIDTH(NS*WW), .DEPTH(CONTROL_POINTS)) u_weight_ram (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wd_w), .rd_data(mem_rd_w)
   );
   swtk_ram #(.WIDTH(NS*BW), .DEPTH(CONTROL_POINTS)) u_bone_ram (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(mem_wd_b), .rd_data(mem_rd_b)
   );

   // ---- divider -------------------------------------------------------------
   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_num, div_quo;

   // the first division starts while the sum is still being registered
   swtk_divider #(.NUM_W(NUM_W), .DEN_W(SW)) u_divider (
      .clock(clock), .reset(reset), .start(div_start),
      .numerator(div_num), .denominator(sum_in),
      .done(div_done), .quotient(div_quo)
   );

   // ---- insertion of a new influence ----------------------------------------
   logic [NS*WW-1:0] ins_w;
   logic [NS*BW-1:0] ins_b;
   logic [SW-1:0]    rd_sum;
   logic [NS-1:0]    gt;

   always_comb begin
      ins_w  = mem_rd_w;
      ins_b  = mem_rd_b;
      rd_sum = '0;
      for (int i = 0; i < NS; i++) begin
         gt[i] = (i < INFLUENCES) && (wgt_ff > mem_rd_w[i*WW +: WW]);
         if (i < INFLUENCES) begin
            rd_sum = rd_sum + SW'(mem_rd_w[i*WW +: WW]);
         end
      end
      // slot i takes the new item at the first greater slot, else its left
      // neighbour once a greater slot lies to its left
      for (int i = 0; i < NS; i++) begin
         if (gt[i] && (i == 0 || !gt[i-1])) begin
            ins_w[i*WW +: WW] = wgt_ff;
            ins_b[i*BW +: BW] = bone_ff;
         end else if (i > 0 && gt[i-1] && i < INFLUENCES) begin
            ins_w[i*WW +: WW] = mem_rd_w[(i-1)*WW +: WW];
            ins_b[i*BW +: BW] = mem_rd_b[(i-1)*BW +: BW];
         end
      end
   end

   // ---- next state ----------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swtk_pkg::ST_INIT: begin
            if (init_ff == ADDR_W'(CONTROL_POINTS - 1)) state_in = swtk_pkg::ST_IDLE;
         end
         swtk_pkg::ST_IDLE: begin
            if (req_valid) state_in = swtk_pkg::ST_FETCH;
         end
         swtk_pkg::ST_FETCH:  state_in = swtk_pkg::ST_MODIFY;
         swtk_pkg::ST_MODIFY: begin
            if (op_ff == swtk_pkg::OP_READ) begin
               if (cp_ok_ff && rd_sum != '0) state_in = swtk_pkg::ST_DIVIDE;
               else                          state_in = swtk_pkg::ST_RESPOND;
            end else begin
               state_in = swtk_pkg::ST_IDLE;
            end
         end
         swtk_pkg::ST_DIVIDE: begin
            if (div_done && slot_ff == SLOT_W'(INFLUENCES - 1)) state_in = swtk_pkg::ST_RESPOND;
         end
         swtk_pkg::ST_RESPOND: begin
            if (rsp_ready) state_in = swtk_pkg::ST_IDLE;
         end
         default: state_in = swtk_pkg::ST_IDLE;
      endcase
   end

   // ---- outputs and datapath ------------------------------------------------
   always_comb begin
      op_in        = op_ff;
      addr_in      = addr_ff;
      cp_ok_in     = cp_ok_ff;
      bone_in      = bone_ff;
      wgt_in       = wgt_ff;
      slot_in      = slot_ff;
      init_in      = init_ff;
      ent_w_in     = ent_w_ff;
      ent_b_in     = ent_b_ff;
      sum_in       = sum_ff;
      res_w_in     = res_w_ff;
      has_in       = has_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = addr_ff;
      mem_wd_w     = ins_w;
      mem_wd_b     = ins_b;
      div_start    = 1'b0;
      div_num      = {ent_w_ff[slot_ff*WW +: WW], 16'd0, 3'd0} >> 3;
      div_num      = div_num + NUM_W'(sum_ff >> 1);
      case (state_ff)
         swtk_pkg::ST_INIT: begin
            // sweep zeros through the store after reset
            mem_we   = 1'b1;
            mem_addr = init_ff;
            mem_wd_w = '0;
            mem_wd_b = '0;
            init_in  = init_ff + 1'b1;
         end
         swtk_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = swtk_pkg::op_type'(req_op);
               cp_ok_in = 32'(req_control_point) < CONTROL_POINTS;
               addr_in  = cp_ok_in ? ADDR_W'(req_control_point) : '0;
               bone_in  = req_bone;
               wgt_in   = (req_weight > swtk_pkg::ONE_Q16) ? swtk_pkg::ONE_Q16 : req_weight;
               if (32'(req_bone) >= BONES) cp_ok_in = 1'b0;
               if (swtk_pkg::op_type'(req_op) != swtk_pkg::OP_ADD) begin
                  cp_ok_in = 32'(req_control_point) < CONTROL_POINTS;
               end
            end
         end
         swtk_pkg::ST_FETCH: begin
            // read issued; data returns next cycle
         end
         swtk_pkg::ST_MODIFY: begin
            ent_w_in = '0;
            ent_b_in = '0;
            for (int i = 0; i < NS; i++) begin
               if (i < INFLUENCES) begin
                  ent_w_in[i*WW +: WW] = mem_rd_w[i*WW +: WW];
                  ent_b_in[i*BW +: BW] = mem_rd_b[i*BW +: BW];
               end
            end
            sum_in   = rd_sum;
            slot_in  = '0;
            res_w_in = ent_w_in;
            has_in   = cp_ok_ff && rd_sum != '0;
            case (op_ff)
               swtk_pkg::OP_ADD: begin
                  mem_we = cp_ok_ff && wgt_ff != '0 && gt != '0;
               end
               swtk_pkg::OP_CLEAR: begin
                  mem_we   = cp_ok_ff;
                  mem_wd_w = '0;
                  mem_wd_b = '0;
               end
               swtk_pkg::OP_READ: begin
                  if (!cp_ok_ff) begin
                     ent_b_in = '0;
                     res_w_in = '0;
                  end
                  if (cp_ok_ff && rd_sum != '0) begin
                     div_start = 1'b1;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
               default: ;
            endcase
            if (op_ff == swtk_pkg::OP_READ && cp_ok_ff && rd_sum != '0) begin
               div_num = {ent_w_in[WW-1:0], 16'd0, 3'd0} >> 3;
               div_num = div_num + NUM_W'(rd_sum >> 1);
            end
         end
         swtk_pkg::ST_DIVIDE: begin
            if (div_done) begin
               res_w_in[slot_ff*WW +: WW] = div_quo[WW-1:0];
               if (slot_ff == SLOT_W'(INFLUENCES - 1)) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  slot_in   = slot_ff + 1'b1;
                  div_start = 1'b1;
                  div_num   = {ent_w_ff[slot_in*WW +: WW], 16'd0, 3'd0} >> 3;
                  div_num   = div_num + NUM_W'(sum_ff >> 1);
               end
            end
         end
         swtk_pkg::ST_RESPOND: begin
            if (rsp_ready) rsp_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swtk_pkg::ST_INIT;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      addr_ff  <= addr_in;
      cp_ok_ff <= cp_ok_in;
      bone_ff  <= bone_in;
      wgt_ff   <= wgt_in;
      slot_ff  <= slot_in;
      ent_w_ff <= ent_w_in;
      ent_b_ff <= ent_b_in;
      sum_ff   <= sum_in;
      res_w_ff <= res_w_in;
      has_ff   <= has_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_weight_0      = res_w_ff[0*WW +: WW];
   assign rsp_weight_1      = res_w_ff[1*WW +: WW];
   assign rsp_weight_2      = res_w_ff[2*WW +: WW];
   assign rsp_weight_3      = res_w_ff[3*WW +: WW];
   assign rsp_bone_0        = ent_b_ff[0*BW +: BW];
   assign rsp_bone_1        = ent_b_ff[1*BW +: BW];
   assign rsp_bone_2        = ent_b_ff[2*BW +: BW];
   assign rsp_bone_3        = ent_b_ff[3*BW +: BW];
   assign rsp_has_influence = has_ff;

endmodule : skin_weight_top_k_normalizer
`default_nettype wire
